[sv/bar_pkg.sv]
// Shared types, constants and config register codes for the button
// auto-repeat block. No dependencies.
`default_nettype none

package bar_pkg;

  // Field geometry fixed by the item format
  localparam int FIELD_PLAYERS = 2;
  localparam int FIELD_BUTTONS = 12;
  localparam int STAMP_W       = 32;
  localparam int CFG_W         = 8;
  localparam int CFG_IDX_W     = 1;

  // Defaults for the top-level parameters
  localparam int NUM_PLAYERS = 2;
  localparam int NUM_BUTTONS = 12;

  // Repeat behavior
  localparam int NUM_REPEAT       = 6;
  localparam int DEFAULT_DELAY    = 15;
  localparam int DEFAULT_INTERVAL = 4;

  typedef logic [FIELD_BUTTONS-1:0] mask_t;
  typedef logic [STAMP_W-1:0]       stamp_t;
  typedef logic [CFG_W-1:0]         cfg_t;

  // Stamp codes: zero is idle, all ones means held since reset
  localparam stamp_t STAMP_IDLE   = '0;
  localparam stamp_t STAMP_IGNORE = '1;
  localparam cfg_t   DELAY_OFF    = 8'hFF;

  // Config register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REPEAT_DELAY    = 1'b0,
    REG_REPEAT_INTERVAL = 1'b1
  } cfg_reg_t;

  // One button entry handed from the sequencer to the update engine
  typedef struct packed {
    logic   vld;
    logic   first;
    logic   last;
    logic   held;
    logic   latched;
    logic   player;
    stamp_t frame;
  } issue_t;

  // Result of the entry in the update stage
  typedef struct packed {
    logic  done;
    mask_t pressed0;
    mask_t pressed1;
  } res_t;

endpackage

`default_nettype wire

[sv/bar_in_if.sv]
// Input item channel: per-player held and latched masks plus frame number.
// Depends on bar_pkg.
`default_nettype none

interface bar_in_if;
  logic           valid;
  logic           ready;
  bar_pkg::mask_t held_player0;
  bar_pkg::mask_t held_player1;
  bar_pkg::mask_t latched_player0;
  bar_pkg::mask_t latched_player1;
  bar_pkg::stamp_t frame_number;

  modport source (output valid, held_player0, held_player1, latched_player0,
                  latched_player1, frame_number, input ready);
  modport sink   (input valid, held_player0, held_player1, latched_player0,
                  latched_player1, frame_number, output ready);
endinterface

`default_nettype wire

[sv/bar_out_if.sv]
// Result item channel: per-player pressed masks.
// Depends on bar_pkg.
`default_nettype none

interface bar_out_if;
  logic           valid;
  logic           ready;
  bar_pkg::mask_t pressed_player0;
  bar_pkg::mask_t pressed_player1;

  modport source (output valid, pressed_player0, pressed_player1, input ready);
  modport sink   (input valid, pressed_player0, pressed_player1, output ready);
endinterface

`default_nettype wire

[sv/button_auto_repeat_top.sv]
// Button auto-repeat top level: config registers, sequencer, stamp engine
// and output register. Depends on bar_pkg, bar_in_if, bar_out_if,
// bar_seq, bar_engine.
//
// Usage:
//   in_item carries, once per frame, each player's held and latched button
//   masks and the frame number. out_item returns one item per input item:
//   the buttons that report a press or a repeat this frame.
//   Each item walks all stamp entries (players x buttons, 24 by default)
//   one per cycle while the pipeline advances; the stamp memory reads one
//   entry and writes back the previous one in the same cycle. The next item is
//   taken on the cycle of the last entry.
//   The finished result sits in an output register while the next item is
//   swept. If the receiver stalls, the sweep runs up to its last entry and
//   then holds until the output register frees.
//   Reset (rst, synchronous) clears the config registers to 0 and marks
//   every stamp entry as held since reset; no clearing pass is needed.
//   Config writes (cfg_we, cfg_index, cfg_data) must be made while idle;
//   the block itself does not enforce this.
`default_nettype none

module button_auto_repeat_top #(
  parameter int NUM_PLAYERS = bar_pkg::NUM_PLAYERS,
  parameter int NUM_BUTTONS = bar_pkg::NUM_BUTTONS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  bar_in_if.sink                             in_item,
  bar_out_if.source                          out_item,
  input  wire logic                          cfg_we,
  input  wire logic [bar_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire bar_pkg::cfg_t                 cfg_data
);

  localparam int EP     = (NUM_PLAYERS < bar_pkg::FIELD_PLAYERS) ?
                          NUM_PLAYERS : bar_pkg::FIELD_PLAYERS;
  localparam int N      = EP * NUM_BUTTONS;
  localparam int ADDR_W = (N > 1) ? $clog2(N) : 1;
  localparam int BTN_W  = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  bar_pkg::cfg_t     repeat_delay;
  bar_pkg::cfg_t     repeat_interval;
  bar_pkg::cfg_t     eff_delay;
  bar_pkg::cfg_t     eff_interval;

  logic              advance;
  bar_pkg::issue_t   issue;
  logic [ADDR_W-1:0] issue_addr;
  logic [BTN_W-1:0]  issue_button;
  bar_pkg::res_t     res;

  logic              out_valid;
  bar_pkg::mask_t    pressed0;
  bar_pkg::mask_t    pressed1;

  // Config register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_delay    <= '0;
      repeat_interval <= '0;
    end else if (cfg_we) begin
      unique case (bar_pkg::cfg_reg_t'(cfg_index))
        bar_pkg::REG_REPEAT_DELAY:    repeat_delay    <= cfg_data;
        bar_pkg::REG_REPEAT_INTERVAL: repeat_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  // Zero selects the default
  assign eff_delay    = (repeat_delay == '0) ?
                        bar_pkg::CFG_W'(bar_pkg::DEFAULT_DELAY) : repeat_delay;
  assign eff_interval = (repeat_interval == '0) ?
                        bar_pkg::CFG_W'(bar_pkg::DEFAULT_INTERVAL) : repeat_interval;

  // Pipeline holds only when a finished item meets a full output register
  assign advance = !(res.done && out_valid && !out_item.ready);

  bar_seq #(
    .NUM_PLAYERS (NUM_PLAYERS),
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_item      (in_item),
    .advance      (advance),
    .issue        (issue),
    .issue_addr   (issue_addr),
    .issue_button (issue_button)
  );

  bar_engine #(
    .NUM_PLAYERS (NUM_PLAYERS),
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .issue        (issue),
    .issue_addr   (issue_addr),
    .issue_button (issue_button),
    .delay        (eff_delay),
    .interval     (eff_interval),
    .res          (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.done) begin
      out_valid <= 1'b1;
    end else if (out_item.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.done) begin
      pressed0 <= res.pressed0;
      pressed1 <= res.pressed1;
    end
  end

  assign out_item.valid           = out_valid;
  assign out_item.pressed_player0 = pressed0;
  assign out_item.pressed_player1 = pressed1;

  // Input is taken only while the pipeline moves
  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    in_item.valid && in_item.ready |-> advance)
    else $error("item accepted during a stall");

  // A stalled finished item is never dropped
  a_done_held: assert property (@(posedge clk) disable iff (rst)
    res.done && !advance |=> res.done)
    else $error("finished item lost while output was full");

  // Output loads only from a finished item
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    !out_valid ##1 out_valid |-> $past(res.done))
    else $error("output became valid without a finished item");

endmodule

`default_nettype wire

[sv/bar_seq.sv]
// Input capture and entry sequencer: walks every (player, button) entry
// of an accepted item, one per cycle while advance is high. Depends on bar_pkg, bar_in_if.
`default_nettype none

module bar_seq #(
  parameter  int NUM_PLAYERS = bar_pkg::NUM_PLAYERS,
  parameter  int NUM_BUTTONS = bar_pkg::NUM_BUTTONS,
  localparam int EP          = (NUM_PLAYERS < bar_pkg::FIELD_PLAYERS) ?
                               NUM_PLAYERS : bar_pkg::FIELD_PLAYERS,
  localparam int N           = EP * NUM_BUTTONS,
  localparam int ADDR_W      = (N > 1) ? $clog2(N) : 1,
  localparam int BTN_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1,
  localparam int NB_IN       = (NUM_BUTTONS < bar_pkg::FIELD_BUTTONS) ?
                               NUM_BUTTONS : bar_pkg::FIELD_BUTTONS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  bar_in_if.sink                      in_item,
  input  wire logic                   advance,
  output bar_pkg::issue_t             issue,
  output logic [ADDR_W-1:0]           issue_addr,
  output logic [BTN_W-1:0]            issue_button
);

  logic              busy;
  logic [ADDR_W-1:0] addr;
  logic [BTN_W-1:0]  button;
  logic              player;
  bar_pkg::mask_t    held_r    [bar_pkg::FIELD_PLAYERS];
  bar_pkg::mask_t    latched_r [bar_pkg::FIELD_PLAYERS];
  bar_pkg::stamp_t   frame_r;

  logic last_entry;
  logic accept;
  logic held_bit;
  logic latched_bit;

  assign last_entry    = (addr == ADDR_W'(N - 1));
  assign in_item.ready = advance && (!busy || last_entry);
  assign accept        = in_item.valid && in_item.ready;

  // Busy flag: set on accept, cleared after the last entry goes out
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (advance && busy && last_entry) begin
      busy <= 1'b0;
    end
  end

  // Entry counters and item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      addr         <= '0;
      button       <= '0;
      player       <= 1'b0;
      held_r[0]    <= in_item.held_player0;
      held_r[1]    <= in_item.held_player1;
      latched_r[0] <= in_item.latched_player0;
      latched_r[1] <= in_item.latched_player1;
      frame_r      <= in_item.frame_number;
    end else if (advance && busy) begin
      addr <= addr + 1'b1;
      if (button == BTN_W'(NUM_BUTTONS - 1)) begin
        button <= '0;
        player <= ~player;
      end else begin
        button <= button + 1'b1;
      end
    end
  end

  // Pick this entry's held and latched bits; buttons past the field are 0
  always_comb begin
    held_bit    = 1'b0;
    latched_bit = 1'b0;
    for (int i = 0; i < NB_IN; i++) begin
      if (button == BTN_W'(i)) begin
        held_bit    = held_r[player][i];
        latched_bit = latched_r[player][i];
      end
    end
  end

  always_comb begin
    issue.vld     = busy;
    issue.first   = (addr == '0);
    issue.last    = last_entry;
    issue.held    = held_bit;
    issue.latched = latched_bit;
    issue.player  = player;
    issue.frame   = frame_r;
    issue_addr    = addr;
    issue_button  = button;
  end

endmodule

`default_nettype wire

[sv/bar_engine.sv]
// Stamp memory with read-modify-write update: per entry a repeat flag and
// a frame stamp, one entry per cycle while advance is high. Depends on bar_pkg.
`default_nettype none

module bar_engine #(
  parameter  int NUM_PLAYERS = bar_pkg::NUM_PLAYERS,
  parameter  int NUM_BUTTONS = bar_pkg::NUM_BUTTONS,
  localparam int EP          = (NUM_PLAYERS < bar_pkg::FIELD_PLAYERS) ?
                               NUM_PLAYERS : bar_pkg::FIELD_PLAYERS,
  localparam int N           = EP * NUM_BUTTONS,
  localparam int ADDR_W      = (N > 1) ? $clog2(N) : 1,
  localparam int BTN_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1,
  localparam int WORD_W      = bar_pkg::STAMP_W + 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   advance,
  input  wire bar_pkg::issue_t        issue,
  input  wire logic [ADDR_W-1:0]      issue_addr,
  input  wire logic [BTN_W-1:0]       issue_button,
  input  wire bar_pkg::cfg_t          delay,
  input  wire bar_pkg::cfg_t          interval,
  output bar_pkg::res_t               res
);

  // Entry word: {repeat flag, stamp}
  logic [WORD_W-1:0] mem [N];
  logic [N-1:0]      ent_valid;

  // Update stage registers
  logic              b_valid;
  logic              b_first;
  logic              b_last;
  logic              b_held;
  logic              b_latched;
  logic              b_player;
  bar_pkg::stamp_t   b_frame;
  logic [ADDR_W-1:0] b_addr;
  logic [BTN_W-1:0]  b_button;
  logic              b_ent_valid;
  logic [WORD_W-1:0] b_rd;

  bar_pkg::mask_t    acc [bar_pkg::FIELD_PLAYERS];
  bar_pkg::mask_t    acc_next [bar_pkg::FIELD_PLAYERS];

  logic              wr_en;
  logic [WORD_W-1:0] wr_data;
  logic              fwd;
  bar_pkg::stamp_t   cur_stamp;
  logic              cur_flag;
  bar_pkg::stamp_t   new_stamp;
  logic              new_flag;
  bar_pkg::stamp_t   elapsed;
  logic              fire;
  logic              can_repeat;
  bar_pkg::mask_t    fire_mask;

  assign wr_en = b_valid && advance;
  assign fwd   = wr_en && (b_addr == issue_addr);

  // Memory write and registered read, with write-to-read forwarding
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[b_addr] <= wr_data;
    end
    if (advance) begin
      b_rd <= fwd ? wr_data : mem[issue_addr];
    end
  end

  // Entry valid bits: an entry never written reads as its reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
    end else if (wr_en) begin
      ent_valid[b_addr] <= 1'b1;
    end
  end

  // Update stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (advance) begin
      b_valid <= issue.vld;
    end
  end

  // Update stage payload
  always_ff @(posedge clk) begin
    if (advance) begin
      b_first     <= issue.first;
      b_last      <= issue.last;
      b_held      <= issue.held;
      b_latched   <= issue.latched;
      b_player    <= issue.player;
      b_frame     <= issue.frame;
      b_addr      <= issue_addr;
      b_button    <= issue_button;
      b_ent_valid <= fwd || ent_valid[issue_addr];
    end
  end

  // Current entry; reset value is the ignore stamp, flag set on button 0
  always_comb begin
    cur_stamp = b_ent_valid ? b_rd[bar_pkg::STAMP_W-1:0] : bar_pkg::STAMP_IGNORE;
    cur_flag  = b_ent_valid ? b_rd[WORD_W-1] : (b_button == '0);
  end

  // Press / repeat decision
  always_comb begin
    elapsed    = b_frame - cur_stamp;
    can_repeat = (32'(b_button) < bar_pkg::NUM_REPEAT);
    new_stamp  = cur_stamp;
    new_flag   = cur_flag;
    fire       = 1'b0;
    if (b_held) begin
      if (cur_stamp == bar_pkg::STAMP_IGNORE) begin
        // held since reset: silent
      end else if (cur_stamp == bar_pkg::STAMP_IDLE) begin
        new_stamp = b_frame;
        fire      = 1'b1;
      end else if (can_repeat) begin
        if ((delay != bar_pkg::DELAY_OFF) && !cur_flag &&
            (elapsed >= bar_pkg::STAMP_W'(delay))) begin
          new_stamp = b_frame;
          new_flag  = 1'b1;
          fire      = 1'b1;
        end else if (cur_flag && (elapsed >= bar_pkg::STAMP_W'(interval))) begin
          new_stamp = b_frame;
          fire      = 1'b1;
        end
      end
    end else begin
      fire = b_latched && (cur_stamp == bar_pkg::STAMP_IDLE);
      if (cur_stamp != bar_pkg::STAMP_IDLE) begin
        new_stamp = bar_pkg::STAMP_IDLE;
        new_flag  = 1'b0;
      end
    end
    wr_data = {new_flag, new_stamp};
  end

  // Merge the fired bit into this item's per-player masks
  always_comb begin
    fire_mask = '0;
    for (int i = 0; i < bar_pkg::FIELD_BUTTONS; i++) begin
      if (i < NUM_BUTTONS) begin
        fire_mask[i] = fire && (b_button == BTN_W'(i));
      end
    end
    for (int p = 0; p < bar_pkg::FIELD_PLAYERS; p++) begin
      acc_next[p] = b_first ? '0 : acc[p];
      if (b_player == p[0]) begin
        acc_next[p] = acc_next[p] | fire_mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      acc <= acc_next;
    end
  end

  always_comb begin
    res.done     = b_valid && b_last;
    res.pressed0 = acc_next[0];
    res.pressed1 = acc_next[1];
  end

  // A stalled update stage keeps its entry
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    b_valid && !advance |=> b_valid && $stable(b_addr))
    else $error("update stage lost its entry during a stall");

  // The last entry of an item is the top address
  a_last_addr: assert property (@(posedge clk) disable iff (rst)
    b_valid && b_last |-> b_addr == ADDR_W'(N - 1))
    else $error("item ended at the wrong entry");

  // Each item starts at entry zero
  a_first_addr: assert property (@(posedge clk) disable iff (rst)
    b_valid && b_first |-> b_addr == '0)
    else $error("item started at a nonzero entry");

endmodule

`default_nettype wire
